>>> src/bias_add_fused_activation_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bias add / fused activation unit
// Both fire on the rising edge of clk and are masked while rst is high.
// ---------------------------------------------------------------------------
`ifndef BIAS_ADD_FUSED_ACTIVATION_UNIT_DEFINES_SVH
`define BIAS_ADD_FUSED_ACTIVATION_UNIT_DEFINES_SVH

// same-cycle implication
`define BAFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BAFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bafa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bafa_pkg
// Types, codes and constants shared by the bias add / fused activation unit,
// including the elaboration-time builder for the tanh lookup ROM.
// ---------------------------------------------------------------------------
package bafa_pkg;

  // element format: signed Q8.8, saturated to this width
  localparam int VALUE_W = 16;
  localparam int INDEX_W = 10;
  localparam logic signed [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam int MAX_CHANNELS_DEF = 1024;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int CH_COUNT_W = 11;
  localparam int SPATIAL_W  = 25;
  localparam int SP_CNT_W   = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS_SRC      = 3'd0,
    CFG_LAYOUT        = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_PLANE_SIZE    = 3'd3,
    CFG_ACTIVATION    = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    BIAS_CHANNEL = 1'b0,
    BIAS_ELEMENT = 1'b1
  } bias_src_t;

  typedef enum logic {
    LAYOUT_NHWC = 1'b0,
    LAYOUT_NCHW = 1'b1
  } layout_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RELU  = 2'd1,
    ACT_RELU6 = 2'd2,
    ACT_TANH  = 2'd3
  } act_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_DATA = 1'b1
  } kind_t;

  // settings the front end needs
  typedef struct packed {
    bias_src_t             bias_src;
    layout_t               layout;
    logic [CH_COUNT_W-1:0] channel_count;
    logic [SPATIAL_W-1:0]  plane_size;
  } front_cfg_t;

  // word handed from front to back
  typedef struct packed {
    logic signed [VALUE_W-1:0] data;
    logic signed [VALUE_W-1:0] bias;
  } mid_word_t;

  // result word
  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      saturated;
  } res_word_t;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // activation limits
  localparam logic signed [VALUE_W-1:0] RELU6_TOP = VALUE_W'(1536);
  localparam logic signed [VALUE_W-1:0] TANH_LO   = -VALUE_W'(1024);
  localparam logic signed [VALUE_W-1:0] TANH_HI   = VALUE_W'(1023);

  // tanh ROM: magnitude 0..1024 in, round(256*tanh(a/256)) out (0..256)
  localparam int TANH_DEPTH = 1025;
  localparam int TANH_AW    = 11;
  localparam int TANH_W     = 9;
  localparam int TANH_FRAC  = 40;

  typedef logic [TANH_W-1:0] tanh_rom_t [TANH_DEPTH];

  // restoring long division, only used while the ROM is built
  function automatic longint unsigned udiv64(longint unsigned dividend,
                                             longint unsigned divisor);
    logic [64:0]     rem;
    longint unsigned quo;
    int              i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], dividend[i]};
      if (rem >= {1'b0, divisor}) begin
        rem    = rem - {1'b0, divisor};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(a/128) by its series in 40-bit fraction fixed point, then
  // tanh = (e-1)/(e+1), rounded half up after scaling by 256
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t rom;
    longint unsigned one;
    longint unsigned term;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    int n;
    int a;
    one = 64'd1 << TANH_FRAC;
    for (a = 0; a < TANH_DEPTH; a++) begin
      term = one;
      e    = one;
      n    = 1;
      while (n < 64 && term != 64'd0) begin
        term = udiv64(term * 64'(a), 64'd128 * 64'(n));
        e    = e + term;
        n    = n + 1;
      end
      num    = (e - one) * 64'd512 + (e + one);
      den    = 64'd2 * (e + one);
      rom[a] = TANH_W'(udiv64(num, den));
    end
    return rom;
  endfunction

endpackage

>>> src/bafa_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bafa_fifo
// Small register FIFO with first-word fall-through read and a fill count.
// ---------------------------------------------------------------------------
module bafa_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wr_data,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/bafa_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bafa_front
// Takes input words, writes bias loads into the bias table, tracks the
// channel and spatial position of data elements and fetches their bias.
// ---------------------------------------------------------------------------
module bafa_front #(
  parameter int MAX_CHANNELS = bafa_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bafa_pkg::front_cfg_t                 cfg,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 kind,
  input  logic [bafa_pkg::INDEX_W-1:0]         bias_index,
  input  logic signed [bafa_pkg::VALUE_W-1:0]  bias_value,
  input  logic signed [bafa_pkg::VALUE_W-1:0]  data_value,
  input  logic                                 first_element,
  output logic                                 mid_push,
  output bafa_pkg::mid_word_t                  mid_word,
  input  logic                                 mid_full
);

  import bafa_pkg::*;

  localparam int CNT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CMP_W = (CNT_W + 1 > CH_COUNT_W) ? CNT_W + 1 : CH_COUNT_W;

  logic                      accept;
  logic                      take_data;
  logic                      take_load;
  logic                      load_in_range;

  logic [CNT_W-1:0]          ch_cnt;
  logic [SP_CNT_W-1:0]       sp_cnt;
  logic [CNT_W-1:0]          base_ch;
  logic [SP_CNT_W-1:0]       base_sp;
  logic [CMP_W-1:0]          ch_inc;
  logic                      ch_wrap;
  logic [CNT_W-1:0]          ch_adv;
  logic [SP_CNT_W:0]         sp_inc;
  logic                      sp_wrap;
  logic [CNT_W-1:0]          ch_cnt_next;
  logic [SP_CNT_W-1:0]       sp_cnt_next;

  logic signed [VALUE_W-1:0] bias_table [MAX_CHANNELS];
  logic signed [VALUE_W-1:0] tbl_q;

  logic                      f1_valid;
  logic signed [VALUE_W-1:0] f1_data;
  logic signed [VALUE_W-1:0] f1_bias;
  logic                      f1_use_table;

  // the single holding stage blocks only when it cannot drain
  assign full          = f1_valid && mid_full;
  assign accept        = push && !full;
  assign take_data     = accept && (kind == KIND_DATA);
  assign take_load     = accept && (kind == KIND_LOAD);
  assign load_in_range = (32'(bias_index) < 32'(MAX_CHANNELS));

  // position of this element, restarted by the first-element mark
  always_comb begin
    base_ch = first_element ? '0 : ch_cnt;
    base_sp = first_element ? '0 : sp_cnt;
    ch_inc  = CMP_W'(base_ch) + 1'b1;
    ch_wrap = (ch_inc >= CMP_W'(cfg.channel_count)) || (ch_inc >= CMP_W'(MAX_CHANNELS));
    ch_adv  = ch_wrap ? '0 : ch_inc[CNT_W-1:0];
    sp_inc  = {1'b0, base_sp} + 1'b1;
    sp_wrap = (sp_inc >= cfg.plane_size) || sp_inc[SP_CNT_W];
    if (cfg.layout == LAYOUT_NHWC) begin
      ch_cnt_next = ch_adv;
      sp_cnt_next = base_sp;
    end else if (sp_wrap) begin
      ch_cnt_next = ch_adv;
      sp_cnt_next = '0;
    end else begin
      ch_cnt_next = base_ch;
      sp_cnt_next = sp_inc[SP_CNT_W-1:0];
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_cnt <= '0;
      sp_cnt <= '0;
    end else if (take_data) begin
      ch_cnt <= ch_cnt_next;
      sp_cnt <= sp_cnt_next;
    end
  end

  // bias table: loads write, data elements read, one or the other per cycle
  always_ff @(posedge clk) begin
    if (take_load && load_in_range) begin
      bias_table[CNT_W'(bias_index)] <= bias_value;
    end
    if (take_data) begin
      tbl_q <= bias_table[base_ch];
    end
  end

  // holding stage, lines up with the table read data
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (take_data) begin
      f1_valid <= 1'b1;
    end else if (mid_push) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_data) begin
      f1_data      <= data_value;
      f1_bias      <= bias_value;
      f1_use_table <= (cfg.bias_src == BIAS_CHANNEL);
    end
  end

  // word to the queue
  assign mid_push      = f1_valid && !mid_full;
  assign mid_word.data = f1_data;
  assign mid_word.bias = f1_use_table ? tbl_q : f1_bias;

endmodule

>>> src/bafa_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bafa_back
// Saturating bias add, then ReLU, ReLU6, tanh (ROM lookup) or none. Two stages,
// never stalled: words are only drawn when the result queue has room.
// ---------------------------------------------------------------------------
module bafa_back (
  input  logic                                       clk,
  input  logic                                       rst,
  input  bafa_pkg::act_t                             act,
  input  logic                                       mid_empty,
  input  bafa_pkg::mid_word_t                        mid_word,
  output logic                                       mid_pop,
  input  logic [$clog2(bafa_pkg::OUT_DEPTH+1)-1:0]   res_count,
  output logic                                       res_push,
  output bafa_pkg::res_word_t                        res_word
);

  import bafa_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  logic [CW:0]               committed;
  logic signed [VALUE_W:0]   wide_sum;
  logic                      sum_sat;
  logic signed [VALUE_W-1:0] sum_clip;

  logic                      b1_valid;
  logic signed [VALUE_W-1:0] b1_sum;
  logic                      b1_sat;

  logic                      sum_neg;
  logic signed [VALUE_W-1:0] neg_sum;
  logic signed [VALUE_W-1:0] plain;
  logic                      use_tanh;
  logic [TANH_AW-1:0]        tanh_addr;

  logic                      b2_valid;
  logic signed [VALUE_W-1:0] b2_plain;
  logic                      b2_tanh;
  logic                      b2_neg;
  logic                      b2_sat;
  logic [TANH_W-1:0]         tanh_q;
  logic signed [VALUE_W-1:0] tanh_ext;

  // credit: queued plus in flight must stay within the result queue
  assign committed = (CW + 1)'(res_count) + (CW + 1)'(b1_valid) + (CW + 1)'(b2_valid);
  assign mid_pop   = !mid_empty && (committed < (CW + 1)'(OUT_DEPTH));

  // add and clamp
  always_comb begin
    wide_sum = {mid_word.data[VALUE_W-1], mid_word.data}
             + {mid_word.bias[VALUE_W-1], mid_word.bias};
    sum_sat  = (wide_sum[VALUE_W] != wide_sum[VALUE_W-1]);
    if (!sum_sat) begin
      sum_clip = wide_sum[VALUE_W-1:0];
    end else if (wide_sum[VALUE_W]) begin
      sum_clip = SAT_MIN;
    end else begin
      sum_clip = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      b1_sum <= sum_clip;
      b1_sat <= sum_sat;
    end
  end

  // activation select and tanh lookup address
  always_comb begin
    sum_neg  = b1_sum[VALUE_W-1];
    neg_sum  = -b1_sum;
    plain    = b1_sum;
    use_tanh = 1'b0;
    case (act)
      ACT_NONE: begin
        plain = b1_sum;
      end
      ACT_RELU: begin
        plain = sum_neg ? '0 : b1_sum;
      end
      ACT_RELU6: begin
        if (sum_neg) begin
          plain = '0;
        end else if (b1_sum > RELU6_TOP) begin
          plain = RELU6_TOP;
        end else begin
          plain = b1_sum;
        end
      end
      ACT_TANH: begin
        use_tanh = 1'b1;
      end
      default: begin
        plain = b1_sum;
      end
    endcase
    if (b1_sum < TANH_LO) begin
      tanh_addr = TANH_AW'(TANH_DEPTH - 1);
    end else if (b1_sum > TANH_HI) begin
      tanh_addr = TANH_AW'(TANH_DEPTH - 2);
    end else if (sum_neg) begin
      tanh_addr = TANH_AW'(neg_sum);
    end else begin
      tanh_addr = TANH_AW'(b1_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      b2_plain <= plain;
      b2_tanh  <= use_tanh;
      b2_neg   <= sum_neg;
      b2_sat   <= b1_sat;
      tanh_q   <= TANH_ROM[tanh_addr];
    end
  end

  // tanh is odd: restore the sign on the way out
  assign tanh_ext = VALUE_W'(tanh_q);
  assign res_push = b2_valid;
  assign res_word.out_value = b2_tanh ? (b2_neg ? -tanh_ext : tanh_ext) : b2_plain;
  assign res_word.saturated = b2_sat;

endmodule

>>> src/bias_add_fused_activation_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bias_add_fused_activation_unit
// Q8.8 bias add with saturation and fused ReLU / ReLU6 / tanh activation.
//
//   channel   handshake          words
//   input     push / full        kind, bias_index, bias_value, data_value,
//                                first_element
//   result    pop / empty        out_value, saturated
//   config    cfg_valid / ready  cfg_index, cfg_data
//
// One word per cycle in and out while full stays low and results are queued. A
// data element passes the holding stage, the middle queue, the back-end add
// and activation stages and the result queue; a bias load gives no result. The
// front-end table read and the back-end tanh ROM read are each registered.
// Reset clears counters, queues and configuration, not the bias table. With
// pop held low the result queue (4 words) then the middle queue (4 words) fill before full rises.
// ---------------------------------------------------------------------------
`include "bias_add_fused_activation_unit_defines.svh"

module bias_add_fused_activation_unit #(
  parameter int MAX_CHANNELS = bafa_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input words
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 kind,
  input  logic [bafa_pkg::INDEX_W-1:0]         bias_index,
  input  logic signed [bafa_pkg::VALUE_W-1:0]  bias_value,
  input  logic signed [bafa_pkg::VALUE_W-1:0]  data_value,
  input  logic                                 first_element,
  // results
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [bafa_pkg::VALUE_W-1:0]  out_value,
  output logic                                 saturated,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bafa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bafa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import bafa_pkg::*;

  localparam int RES_CW = $clog2(OUT_DEPTH + 1);
  localparam int MID_CW = $clog2(MID_DEPTH + 1);

  front_cfg_t          fcfg;
  act_t                act;

  logic                mid_push;
  mid_word_t           mid_in;
  logic                mid_full;
  logic                mid_pop;
  mid_word_t           mid_out;
  logic                mid_empty;
  logic [MID_CW-1:0]   mid_count;

  logic                res_push;
  res_word_t           res_in;
  logic                res_full;
  res_word_t           res_out;
  logic [RES_CW-1:0]   res_count;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcfg.bias_src      <= BIAS_CHANNEL;
      fcfg.layout        <= LAYOUT_NHWC;
      fcfg.channel_count <= CH_COUNT_W'(1);
      fcfg.plane_size    <= SPATIAL_W'(1);
      act                <= ACT_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIAS_SRC:      fcfg.bias_src      <= bias_src_t'(cfg_data[0]);
        CFG_LAYOUT:        fcfg.layout        <= layout_t'(cfg_data[0]);
        CFG_CHANNEL_COUNT: fcfg.channel_count <= cfg_data[CH_COUNT_W-1:0];
        CFG_PLANE_SIZE:    fcfg.plane_size    <= cfg_data[SPATIAL_W-1:0];
        CFG_ACTIVATION:    act                <= act_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // front end: table and position tracking
  bafa_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (fcfg),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .bias_index    (bias_index),
    .bias_value    (bias_value),
    .data_value    (data_value),
    .first_element (first_element),
    .mid_push      (mid_push),
    .mid_word      (mid_in),
    .mid_full      (mid_full)
  );

  // queue between front and back
  bafa_fifo #(
    .WIDTH ($bits(mid_word_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_in),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_out),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  // back end: add, clamp, activate
  bafa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .act       (act),
    .mid_empty (mid_empty),
    .mid_word  (mid_out),
    .mid_pop   (mid_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_word  (res_in)
  );

  // result queue
  bafa_fifo #(
    .WIDTH ($bits(res_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_out),
    .empty   (empty),
    .count   (res_count)
  );

  assign out_value = res_out.out_value;
  assign saturated = res_out.saturated;

  // checks
  `BAFA_ASSERT_IMP(a_res_no_overflow, res_push, !res_full, "result queue overrun")
  `BAFA_ASSERT_IMP(a_mid_no_overflow, mid_push, !mid_full, "middle queue overrun")
  `BAFA_ASSERT_IMP(a_mid_no_underrun, mid_pop, !mid_empty, "middle queue underrun")
  `BAFA_ASSERT_NXT(a_mid_fill, mid_push && !mid_pop, mid_count != '0, "middle queue lost a word")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bias add / fused activation unit. It fills the
// reachable part of the bias table and runs short directed checks on
// saturation, each activation and the channel counters. Random tensors
// follow, over a spread of layouts, channel counts, plane sizes and bias
// modes, with both sides stalling in bursts. A behavioural predictor works
// out every result word, and each popped word is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bafa_pkg::*;

  localparam int     CLK_HALF      = 6;
  localparam int     TABLE_DEPTH   = 1024;
  localparam int     PRELOAD_DEPTH = 256;
  localparam int     PLANE_CAP     = 1 << 24;
  localparam int     DRAIN_CYCLES  = 16;
  localparam int     MAX_REPORTS   = 10;
  localparam longint LIMIT_NS      = 64'd12_000_000;

  // DUT ports
  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       push          = 1'b0;
  logic                       full;
  logic                       kind          = 1'b0;
  logic [INDEX_W-1:0]         bias_index    = '0;
  logic signed [VALUE_W-1:0]  bias_value    = '0;
  logic signed [VALUE_W-1:0]  data_value    = '0;
  logic                       first_element = 1'b0;
  logic                       empty;
  logic                       pop           = 1'b0;
  logic signed [VALUE_W-1:0]  out_value;
  logic                       saturated;
  logic                       cfg_valid     = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index     = '0;
  logic [CFG_DATA_W-1:0]      cfg_data      = '0;

  // predictor state
  logic signed [VALUE_W-1:0]  bias_mem [TABLE_DEPTH];
  logic [INDEX_W-1:0]         chan_pos      = '0;
  logic [SP_CNT_W-1:0]        plane_pos     = '0;
  bias_src_t                  p_bias_src    = BIAS_CHANNEL;
  layout_t                    p_layout      = LAYOUT_NHWC;
  logic [CH_COUNT_W-1:0]      p_ch_count    = CH_COUNT_W'(1);
  logic [SPATIAL_W-1:0]       p_plane_size  = SPATIAL_W'(1);
  act_t                       p_act         = ACT_NONE;
  int                         tanh_lut [0:1024];

  res_word_t                  awaited_words [$];
  int                         error_count   = 0;
  bit                         idle_en       = 1'b1;
  int                         stall_left    = 0;

  bias_add_fused_activation_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .bias_index    (bias_index),
    .bias_value    (bias_value),
    .data_value    (data_value),
    .first_element (first_element),
    .empty         (empty),
    .pop           (pop),
    .out_value     (out_value),
    .saturated     (saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 12 ns clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // channel wraps at channel_count, or at the table depth
  function automatic void step_channel();
    int nxt;
    nxt = int'(chan_pos) + 1;
    if (nxt >= int'(p_ch_count) || nxt >= TABLE_DEPTH) begin
      chan_pos = '0;
    end else begin
      chan_pos = INDEX_W'(nxt);
    end
  endfunction

  // one accepted input word: update the table or queue the expected result
  function automatic void predict_word(kind_t k, logic [INDEX_W-1:0] idx,
                                       logic signed [VALUE_W-1:0] b_in,
                                       logic signed [VALUE_W-1:0] d_in,
                                       logic first);
    int        addend;
    int        total;
    int        shaped;
    int        clipped;
    int        pnext;
    logic      sat_flag;
    res_word_t w;
    if (k == KIND_LOAD) begin
      bias_mem[idx] = b_in;
      return;
    end
    if (first) begin
      chan_pos  = '0;
      plane_pos = '0;
    end
    addend = (p_bias_src == BIAS_CHANNEL) ? int'(bias_mem[chan_pos]) : int'(b_in);

    // saturating add
    total    = int'(d_in) + addend;
    sat_flag = 1'b0;
    if (total > int'(SAT_MAX)) begin
      total    = int'(SAT_MAX);
      sat_flag = 1'b1;
    end else if (total < int'(SAT_MIN)) begin
      total    = int'(SAT_MIN);
      sat_flag = 1'b1;
    end

    // activation
    case (p_act)
      ACT_RELU:  shaped = (total < 0) ? 0 : total;
      ACT_RELU6: shaped = (total < 0) ? 0 :
                          ((total > int'(RELU6_TOP)) ? int'(RELU6_TOP) : total);
      ACT_TANH: begin
        clipped = (total < int'(TANH_LO)) ? int'(TANH_LO) :
                  ((total > int'(TANH_HI)) ? int'(TANH_HI) : total);
        shaped  = (clipped < 0) ? -tanh_lut[-clipped] : tanh_lut[clipped];
      end
      default:   shaped = total;
    endcase

    // counters
    if (p_layout == LAYOUT_NHWC) begin
      step_channel();
    end else begin
      pnext = int'(plane_pos) + 1;
      if (pnext >= int'(p_plane_size) || pnext >= PLANE_CAP) begin
        plane_pos = '0;
        step_channel();
      end else begin
        plane_pos = SP_CNT_W'(pnext);
      end
    end

    w.out_value = VALUE_W'(shaped);
    w.saturated = sat_flag;
    awaited_words.push_back(w);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Q8.8 values weighted toward the saturation and activation edges
  function automatic logic signed [VALUE_W-1:0] pick_q88();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return '0;
          3:       return RELU6_TOP;
          4:       return VALUE_W'(1537);
          5:       return VALUE_W'(-1025);
          6:       return VALUE_W'(1024);
          default: return VALUE_W'(-1);
        endcase
      end
      1, 2, 3: return VALUE_W'($urandom);
      4, 5, 6: return VALUE_W'(int'($urandom_range(0, 2400)) - 1200);
      default: return VALUE_W'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  // drive one input word and wait for it to be taken
  task automatic send_word(kind_t k, logic [INDEX_W-1:0] idx,
                           logic signed [VALUE_W-1:0] b_in,
                           logic signed [VALUE_W-1:0] d_in, logic first);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push          <= 1'b1;
    kind          <= k;
    bias_index    <= idx;
    bias_value    <= b_in;
    data_value    <= d_in;
    first_element <= first;
    do @(posedge clk); while (full);
    predict_word(k, idx, b_in, d_in, first);
  endtask

  task automatic load_bias(logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] val);
    send_word(KIND_LOAD, idx, val, VALUE_W'($urandom), 1'($urandom));
  endtask

  task automatic push_element(logic signed [VALUE_W-1:0] b_in,
                              logic signed [VALUE_W-1:0] d_in, logic first);
    send_word(KIND_DATA, INDEX_W'($urandom), b_in, d_in, first);
  endtask

  // input low, every result back, pipeline given time to empty
  task automatic wait_quiet();
    @(negedge clk);
    push <= 1'b0;
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      CFG_BIAS_SRC:      p_bias_src   = bias_src_t'(v[0]);
      CFG_LAYOUT:        p_layout     = layout_t'(v[0]);
      CFG_CHANNEL_COUNT: p_ch_count   = v[CH_COUNT_W-1:0];
      CFG_PLANE_SIZE:    p_plane_size = v[SPATIAL_W-1:0];
      CFG_ACTIVATION:    p_act        = act_t'(v[1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(bias_src_t m, layout_t l, int ch, int sp, act_t a);
    write_reg(CFG_BIAS_SRC, CFG_DATA_W'(m));
    write_reg(CFG_LAYOUT, CFG_DATA_W'(l));
    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(ch));
    write_reg(CFG_PLANE_SIZE, CFG_DATA_W'(sp));
    write_reg(CFG_ACTIVATION, CFG_DATA_W'(a));
  endtask

  // random settings, then tensors: mostly well formed, some without the
  // first-element mark and some with stray marks mid-stream; the first
  // element of a phase is always marked, so the channel stays inside the
  // preloaded entries
  task automatic run_tensor_phase(int n_words);
    bias_src_t  m;
    layout_t    l;
    act_t       a;
    int         ch;
    int         sp;
    int         sent;
    int         run_len;
    int         i;
    longint     total;
    bit         clean;
    logic       mark;
    m = bias_src_t'($urandom_range(0, 1));
    l = layout_t'($urandom_range(0, 1));
    a = act_t'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       ch = 1;
      1:       ch = TABLE_DEPTH;
      2:       ch = $urandom_range(2, 8);
      default: ch = $urandom_range(1, TABLE_DEPTH);
    endcase
    case ($urandom_range(0, 15))
      0:             sp = PLANE_CAP;
      1, 2, 3, 4:    sp = 1;
      5, 6, 7, 8, 9: sp = $urandom_range(2, 6);
      default:       sp = $urandom_range(1, 40);
    endcase
    configure(m, l, ch, sp, a);
    sent = 0;
    while (sent < n_words) begin
      total   = longint'(ch) * longint'(sp);
      run_len = $urandom_range(4, 60);
      if (total < run_len) run_len = int'(total);
      if (run_len > n_words - sent) run_len = n_words - sent;
      clean = ($urandom_range(0, 5) != 0) || (sent == 0);
      for (i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 19) == 0) load_bias(INDEX_W'($urandom), pick_q88());
        mark = (i == 0) ? clean : ($urandom_range(0, 39) == 0);
        push_element(pick_q88(), pick_q88(), mark);
      end
      sent += run_len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // every entry the element tests can reach written before any element
  task automatic test_table_preload();
    int i;
    for (i = 0; i < PRELOAD_DEPTH; i++) load_bias(INDEX_W'(i), pick_q88());
  endtask

  task automatic test_saturation();
    configure(BIAS_ELEMENT, LAYOUT_NHWC, 1, 1, ACT_NONE);
    push_element(SAT_MAX, SAT_MAX, 1'b1);
    push_element(SAT_MIN, SAT_MIN, 1'b0);
    push_element(VALUE_W'(1), SAT_MAX, 1'b0);
    push_element(VALUE_W'(-1), SAT_MAX, 1'b0);
  endtask

  // below zero, just over 6.0 / tanh clamp, and an ordinary value
  task automatic test_activations();
    act_t acts [3];
    int   i;
    acts = '{ACT_RELU, ACT_RELU6, ACT_TANH};
    for (i = 0; i < 3; i++) begin
      configure(BIAS_ELEMENT, LAYOUT_NHWC, 1, 1, acts[i]);
      push_element('0, VALUE_W'(-1025), 1'b1);
      push_element('0, VALUE_W'(1537), 1'b0);
      push_element(VALUE_W'(100), VALUE_W'(28), 1'b0);
    end
  endtask

  // table lookup as the channel walks, in both orders
  task automatic test_channel_walk();
    int i;
    configure(BIAS_CHANNEL, LAYOUT_NHWC, 3, 1, ACT_NONE);
    load_bias(INDEX_W'(0), SAT_MAX);
    load_bias(INDEX_W'(1), SAT_MIN);
    load_bias(INDEX_W'(2), VALUE_W'(256));
    push_element(pick_q88(), VALUE_W'(1), 1'b1);
    push_element(pick_q88(), VALUE_W'(-1), 1'b0);
    push_element(pick_q88(), '0, 1'b0);
    push_element(pick_q88(), SAT_MIN, 1'b0);
    configure(BIAS_CHANNEL, LAYOUT_NCHW, 2, 2, ACT_NONE);
    for (i = 0; i < 5; i++) push_element(pick_q88(), pick_q88(), i == 0);
  endtask

  task automatic test_counter_extremes();
    configure(BIAS_CHANNEL, LAYOUT_NCHW, TABLE_DEPTH, PLANE_CAP, ACT_TANH);
    push_element(pick_q88(), pick_q88(), 1'b1);
    push_element(pick_q88(), pick_q88(), 1'b0);
    configure(BIAS_CHANNEL, LAYOUT_NHWC, TABLE_DEPTH, 1, ACT_RELU6);
    push_element(pick_q88(), pick_q88(), 1'b1);
    push_element(pick_q88(), pick_q88(), 1'b0);
  endtask

  task automatic test_random_tensors();
    int ph;
    for (ph = 0; ph < 10; ph++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      run_tensor_phase(75);
    end
  endtask

  // full rate on both sides
  task automatic test_unthrottled();
    idle_en = 1'b0;
    run_tensor_phase(100);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop with random stall bursts, check every popped word
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(0, 17);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    res_word_t want;
    if (!rst && pop && !empty) begin
      if (awaited_words.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("[%0t] result word with none expected: out_value=%0d saturated=%0b",
                   $time, out_value, saturated);
      end else begin
        want = awaited_words.pop_front();
        if (out_value !== want.out_value || saturated !== want.saturated) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: expected %0d sat %0b, actual %0d sat %0b",
                     $time, want.out_value, want.saturated, out_value, saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    longint unsigned unit_v;
    longint unsigned term;
    longint unsigned exp_sum;
    int              mag;
    int              k;

    // tanh magnitudes: exp(a/128) by its series with a 40-bit fraction,
    // then (e-1)/(e+1) scaled by 256 and rounded half up
    unit_v = 64'd1 << 40;
    for (mag = 0; mag <= 1024; mag++) begin
      term    = unit_v;
      exp_sum = unit_v;
      for (k = 1; k < 64 && term != 0; k++) begin
        term    = term * 64'(mag) / (64'd128 * 64'(k));
        exp_sum = exp_sum + term;
      end
      tanh_lut[mag] = int'(((exp_sum - unit_v) * 64'd512 + (exp_sum + unit_v)) /
                           (64'd2 * (exp_sum + unit_v)));
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_table_preload();
    test_saturation();
    test_activations();
    test_channel_walk();
    test_counter_extremes();
    test_random_tensors();
    test_unthrottled();
    wait_quiet();

    if (error_count == 0 && awaited_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
